// ----- rtl/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants of the RPN stack engine.
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int unsigned STACK_DEPTH = 128;
	localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
	localparam int unsigned DEPTH_OUT_W = 8;

	localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

	localparam logic [3:0] CMD_PUSH  = 4'd0;
	localparam logic [3:0] CMD_ADD   = 4'd1;
	localparam logic [3:0] CMD_SUB   = 4'd2;
	localparam logic [3:0] CMD_MUL   = 4'd3;
	localparam logic [3:0] CMD_DIV   = 4'd4;
	localparam logic [3:0] CMD_MOD   = 4'd5;
	localparam logic [3:0] CMD_PEEK  = 4'd6;
	localparam logic [3:0] CMD_DUP   = 4'd7;
	localparam logic [3:0] CMD_SWAP  = 4'd8;
	localparam logic [3:0] CMD_CLEAR = 4'd9;
	localparam logic [3:0] CMD_POP   = 4'd10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_WAIT,
		ST_OP,
		ST_ALU,
		ST_MUL,
		ST_DIV,
		ST_WR1,
		ST_WR2,
		ST_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic       load_cmd;   // capture the request
		logic       pop_y;      // pop into y
		logic       pop_x;      // pop into x
		logic       latch_y;    // take read data into y
		logic       latch_x;    // take read data into x
		logic       peek;       // read top without popping
		logic       latch_show;
		logic       mul_start;
		logic       div_start;
		logic       latch_alu;  // compute add/sub/mod-free results
		logic       push_r;     // push result register
		logic       push_x;
		logic       push_y;
		logic       clear_sp;
		logic       set_dz;
		logic       out_load;
	} ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic       y_zero;
		logic       mul_done;
		logic       div_done;
		logic       out_full;
		logic       sp_empty;
	} sts_t;

endpackage

// ----- rtl/rpn_stack_alu_unit.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_alu_unit
// Reverse-Polish stack engine over signed Q31.32 values.
// ----------------------------------------------------------------------------
// One request at a time. Mul forms four 32x32 partial products; div and mod
// run the one-bit-per-cycle shift-subtract divider, unless they meet a zero
// divisor. The result appears in the cycle the engine is ready again; a result
// the receiver does not take holds the engine until it does. The stack is a
// 128-entry memory with one port; it needs no clearing after reset.
module rpn_stack_alu_unit import rsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [3:0] cmd, [67:4] push_value, [71:68] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // [63:0] result_value, [64] value_valid,
	                               // [65] underflow_flag, [66] overflow_flag,
	                               // [67] divide_by_zero, [75:68] stack_depth
);

	ctl_t ctl;
	sts_t sts;
	logic idle;
	logic [3:0] cmd_r;
	logic [63:0] result_value;
	logic value_valid, underflow_flag, overflow_flag, divide_by_zero;
	logic [DEPTH_OUT_W-1:0] stack_depth;

	assign s_tready = idle;

	rsa_control u_ctl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.cmd_r(cmd_r), .sts(sts), .ctl(ctl), .idle(idle)
	);

	rsa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.cmd(s_tdata[3:0]), .push_value(s_tdata[67:4]), .cmd_r(cmd_r),
		.out_take(m_tready), .out_valid(m_tvalid),
		.result_value(result_value), .value_valid(value_valid),
		.underflow_flag(underflow_flag), .overflow_flag(overflow_flag),
		.divide_by_zero(divide_by_zero), .stack_depth(stack_depth)
	);

	assign m_tdata = {4'd0, stack_depth, divide_by_zero, overflow_flag,
		underflow_flag, value_valid, result_value};

endmodule

// ----- rtl/rsa_divider.sv -----
// ----------------------------------------------------------------------------
// rsa_divider
// Restoring shift-subtract divider of a 96-bit dividend by a 64-bit divisor,
// one quotient bit per cycle, returning quotient and remainder magnitudes.
// ----------------------------------------------------------------------------
module rsa_divider import rsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        frac,       // 1: dividend is a<<32, 96 steps; 0: 64 steps
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic        q_ovf,
	output logic [63:0] remainder
);

	logic [95:0] num_q;
	logic [64:0] rem_q;
	logic [63:0] den_q;
	logic [63:0] quo_q;
	logic        ovf_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q[63:0], num_q[95]};
	assign fits = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= frac ? 7'd96 : 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= frac ? {dividend, 32'd0} : {dividend, 32'd0};
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[94:0], 1'b0};
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			if (quo_q[63]) ovf_q <= 1'b1;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign quotient = quo_q;
	assign q_ovf = ovf_q;
	assign remainder = rem_q[63:0];

endmodule

// ----- rtl/rsa_datapath.sv -----
// ----------------------------------------------------------------------------
// rsa_datapath
// Stack memory, operand registers, saturating arithmetic, multiplier and
// divider, and the output register.
// ----------------------------------------------------------------------------
module rsa_datapath import rsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_t                   ctl,
	output sts_t                   sts,
	input  logic [3:0]             cmd,
	input  logic [63:0]            push_value,
	output logic [3:0]             cmd_r,
	input  logic                   out_take,
	output logic                   out_valid,
	output logic [63:0]            result_value,
	output logic                   value_valid,
	output logic                   underflow_flag,
	output logic                   overflow_flag,
	output logic                   divide_by_zero,
	output logic [DEPTH_OUT_W-1:0] stack_depth
);

	logic [63:0] mem [STACK_DEPTH];
	logic [63:0] rd_q;
	logic [SP_W-1:0] sp_q;
	logic [3:0]  cmd_q;
	logic [63:0] x_q, y_q, r_q, show_q;
	logic        under_q, over_q, dz_q, vv_q;
	logic        out_valid_q;
	logic [63:0] out_val_q;
	logic        out_vv_q, out_un_q, out_ov_q, out_dz_q;
	logic [DEPTH_OUT_W-1:0] out_sp_q;

	logic        do_pop, do_push;
	logic [63:0] wr_data;
	logic [SP_W-1:0] sp_dec;

	assign do_pop = ctl.pop_x | ctl.pop_y | ctl.peek;
	assign do_push = ctl.push_r | ctl.push_x | ctl.push_y;
	assign wr_data = ctl.push_r ? r_q : (ctl.push_x ? x_q : y_q);
	assign sp_dec = sp_q - SP_W'(1);

	// Memory: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (do_push && sp_q < SP_W'(STACK_DEPTH))
			mem[sp_q[ADDR_W-1:0]] <= wr_data;
		if (do_pop && sp_q != '0)
			rd_q <= mem[sp_dec[ADDR_W-1:0]];
	end

	// Magnitudes and signs of operands.
	logic [63:0] ma, mb;
	logic        neg;
	assign ma = x_q[63] ? -x_q : x_q;
	assign mb = y_q[63] ? -y_q : y_q;
	assign neg = x_q[63] ^ y_q[63];

	// Multiplier: four 32x32 partial products, formed a pair at a time.
	logic [1:0]   mstep_q;
	logic [63:0]  p00_q, p01_q, p10_q, p11_q;
	logic         mul_done_q;
	logic [127:0] prod;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_q <= '0;
			mul_done_q <= 1'b0;
		end else begin
			mul_done_q <= mstep_q == 2'd2;
			if (ctl.mul_start) mstep_q <= 2'd1;
			else if (mstep_q == 2'd1) mstep_q <= 2'd2;
			else mstep_q <= '0;
		end
	end
	always_ff @(posedge clk) begin
		if (mstep_q == 2'd1) begin
			p00_q <= ma[31:0] * mb[31:0];
			p01_q <= ma[31:0] * mb[63:32];
		end
		if (mstep_q == 2'd2) begin
			p10_q <= ma[63:32] * mb[31:0];
			p11_q <= ma[63:32] * mb[63:32];
		end
	end
	assign prod = {p11_q, 64'd0} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
		+ {64'd0, p00_q};

	// Divider.
	logic        div_done;
	logic [63:0] quo, rem;
	logic        q_ovf;
	rsa_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.frac(cmd_q == CMD_DIV), .dividend(ma), .divisor(mb),
		.done(div_done), .quotient(quo), .q_ovf(q_ovf), .remainder(rem)
	);

	function automatic logic [63:0] sat_sign(input logic [63:0] m, input logic ovf,
			input logic n);
		logic [63:0] lim;
		lim = n ? SMIN : SMAX;
		if (ovf || m > lim) return lim;
		return n ? -m : m;
	endfunction

	logic [63:0] sum, dif;
	assign sum = x_q + y_q;
	assign dif = x_q - y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			if (ctl.clear_sp) sp_q <= '0;
			else if (do_push && sp_q < SP_W'(STACK_DEPTH)) sp_q <= sp_q + SP_W'(1);
			else if ((ctl.pop_x || ctl.pop_y) && sp_q != '0) sp_q <= sp_dec;
		end
	end

	// Zero read data from an empty pop: clear operand when nothing was read.
	logic rd_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_valid_q <= 1'b0;
		else rd_valid_q <= do_pop && sp_q != '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_cmd) begin
			cmd_q <= cmd;
			x_q <= '0;
			y_q <= '0;
			r_q <= push_value;
			show_q <= '0;
			under_q <= 1'b0;
			over_q <= 1'b0;
			dz_q <= 1'b0;
			vv_q <= 1'b0;
		end else begin
			if ((ctl.pop_x || ctl.pop_y) && sp_q == '0) under_q <= 1'b1;
			if (do_push && sp_q >= SP_W'(STACK_DEPTH)) over_q <= 1'b1;
			if (ctl.latch_y) y_q <= rd_q;
			if (ctl.latch_x) x_q <= rd_q;
			if (ctl.latch_show) begin
				show_q <= rd_valid_q ? rd_q : '0;
				vv_q <= 1'b1;
			end
			if (ctl.set_dz) dz_q <= 1'b1;
			if (ctl.latch_alu) begin
				if (cmd_q == CMD_ADD)
					r_q <= (~(x_q[63] ^ y_q[63]) & (x_q[63] ^ sum[63]))
						? (x_q[63] ? SMIN : SMAX) : sum;
				else
					r_q <= ((x_q[63] ^ y_q[63]) & (x_q[63] ^ dif[63]))
						? (x_q[63] ? SMIN : SMAX) : dif;
			end
			if (mul_done_q)
				r_q <= sat_sign(prod[95:32], prod[127:96] != '0, neg);
			if (div_done) begin
				if (cmd_q == CMD_DIV) r_q <= sat_sign(quo, q_ovf, neg);
				else r_q <= x_q[63] ? -rem : rem;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ctl.out_load) out_valid_q <= 1'b1;
		else if (out_take) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_val_q <= show_q;
			out_vv_q <= vv_q;
			out_un_q <= under_q;
			out_ov_q <= over_q;
			out_dz_q <= dz_q;
			out_sp_q <= DEPTH_OUT_W'(sp_q);
		end
	end

	assign sts.y_zero = y_q == '0;
	assign sts.mul_done = mul_done_q;
	assign sts.div_done = div_done;
	assign sts.out_full = out_valid_q && !out_take;
	assign sts.sp_empty = sp_q == '0;
	assign cmd_r = cmd_q;
	assign out_valid = out_valid_q;
	assign result_value = out_val_q;
	assign value_valid = out_vv_q;
	assign underflow_flag = out_un_q;
	assign overflow_flag = out_ov_q;
	assign divide_by_zero = out_dz_q;
	assign stack_depth = out_sp_q;

	// The stack pointer never passes the depth.
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH)) else $error("stack pointer out of range");
	// Multiplier and divider never finish together.
	a_units: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done_q && div_done)) else $error("unit completion clash");
	// A push and a pop never come in one cycle.
	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_push && do_pop)) else $error("push and pop together");

endmodule

// ----- rtl/rsa_control.sv -----
// ----------------------------------------------------------------------------
// rsa_control
// Sequencer that pops operands, starts the arithmetic units, pushes results
// and loads the output register for each request.
// ----------------------------------------------------------------------------
module rsa_control import rsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [3:0] cmd_r,
	input  sts_t       sts,
	output ctl_t       ctl,
	output logic       idle
);

	state_t state_q, state_d;
	logic   two_ops;
	logic   pop_second;
	logic   sts_empty_prev;
	logic   op_q;

	// Commands that pop y then x. Swap pops into x first, then y.
	assign two_ops = cmd_r == CMD_ADD || cmd_r == CMD_SUB || cmd_r == CMD_MUL
		|| cmd_r == CMD_DIV || cmd_r == CMD_MOD || cmd_r == CMD_SWAP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign pop_second = two_ops;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_RD1;
			ST_RD1: begin
				unique case (cmd_r) inside
					CMD_PUSH: state_d = ST_WR1;
					CMD_CLEAR: state_d = ST_DONE;
					CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_PEEK, CMD_DUP,
					CMD_SWAP, CMD_POP: state_d = ST_WAIT;
					default: state_d = ST_DONE;
				endcase
			end
			ST_WAIT: begin
				if (cmd_r == CMD_PEEK || cmd_r == CMD_POP) state_d = ST_DONE;
				else if (cmd_r == CMD_DUP) state_d = ST_WR1;
				else state_d = ST_RD2;
			end
			ST_RD2: begin
				// Zero divisor: stop before popping the dividend.
				if ((cmd_r == CMD_DIV || cmd_r == CMD_MOD) && sts.y_zero) state_d = ST_DONE;
				else if (pop_second) state_d = ST_OP;
				else state_d = ST_DONE;
			end
			ST_OP: begin
				unique case (cmd_r) inside
					CMD_ADD, CMD_SUB: state_d = ST_ALU;
					CMD_MUL: state_d = ST_MUL;
					CMD_DIV, CMD_MOD: state_d = ST_DIV;
					default: state_d = ST_WR1;
				endcase
			end
			ST_ALU: state_d = ST_WR1;
			ST_MUL: if (sts.mul_done) state_d = ST_WR1;
			ST_DIV: if (sts.div_done) state_d = ST_WR1;
			ST_WR1: begin
				if (cmd_r == CMD_DUP || cmd_r == CMD_SWAP) state_d = ST_WR2;
				else state_d = ST_DONE;
			end
			ST_WR2: state_d = ST_DONE;
			ST_DONE: if (!sts.out_full) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic rd2_pop;
	assign rd2_pop = !((cmd_r == CMD_DIV || cmd_r == CMD_MOD) && sts.y_zero);

	always_comb begin
		ctl = '0;
		idle = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				ctl.load_cmd = in_fire;
			end
			ST_RD1: begin
				// First pop: y for arithmetic, x for dup and swap, top for show.
				ctl.peek = cmd_r == CMD_PEEK;
				ctl.pop_y = cmd_r == CMD_ADD || cmd_r == CMD_SUB || cmd_r == CMD_MUL
					|| cmd_r == CMD_DIV || cmd_r == CMD_MOD || cmd_r == CMD_POP;
				ctl.pop_x = cmd_r == CMD_DUP || cmd_r == CMD_SWAP;
				ctl.clear_sp = cmd_r == CMD_CLEAR;
			end
			ST_WAIT: begin
				// Read data of the first pop arrives; an empty read stays zero.
				ctl.latch_y = !sts_empty_prev && (cmd_r != CMD_DUP && cmd_r != CMD_SWAP
					&& cmd_r != CMD_PEEK && cmd_r != CMD_POP);
				ctl.latch_x = !sts_empty_prev && (cmd_r == CMD_DUP || cmd_r == CMD_SWAP);
				ctl.latch_show = (cmd_r == CMD_POP) || (!sts_empty_prev && cmd_r == CMD_PEEK);
				ctl.push_x = 1'b0;
			end
			ST_RD2: begin
				ctl.set_dz = !rd2_pop;
				ctl.pop_x = rd2_pop && cmd_r != CMD_SWAP;
				ctl.pop_y = rd2_pop && cmd_r == CMD_SWAP;
			end
			ST_OP: begin
				ctl.latch_x = !sts_empty_prev && cmd_r != CMD_SWAP;
				ctl.latch_y = !sts_empty_prev && cmd_r == CMD_SWAP;
			end
			ST_ALU: ctl.latch_alu = 1'b1;
			ST_MUL: ;
			ST_DIV: ;
			ST_WR1: begin
				ctl.push_r = cmd_r == CMD_PUSH || cmd_r == CMD_ADD || cmd_r == CMD_SUB
					|| cmd_r == CMD_MUL || cmd_r == CMD_DIV || cmd_r == CMD_MOD;
				ctl.push_x = cmd_r == CMD_DUP || cmd_r == CMD_SWAP;
			end
			ST_WR2: begin
				ctl.push_x = cmd_r == CMD_DUP;
				ctl.push_y = cmd_r == CMD_SWAP;
			end
			ST_DONE: ctl.out_load = !sts.out_full;
			default: ;
		endcase
		// Units start in the first cycle of their wait states, once both operands
		// are in their registers.
		ctl.mul_start = op_q && cmd_r == CMD_MUL;
		ctl.div_start = op_q && (cmd_r == CMD_DIV || cmd_r == CMD_MOD);
	end

	// Stack-empty at the time of the previous pop: a popped operand is valid only
	// when the stack was not empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sts_empty_prev <= 1'b1;
		else sts_empty_prev <= sts.sp_empty;
	end

	// Unit starts are registered from the operand-latch state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) op_q <= 1'b0;
		else op_q <= state_q == ST_OP;
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_cmd |-> state_q == ST_IDLE) else $error("load outside idle");
	a_done_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_full) |=> state_q == ST_IDLE)
		else $error("done did not return to idle");
	a_one_push: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctl.push_r, ctl.push_x, ctl.push_y}) <= 1)
		else $error("multiple push sources");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RPN stack engine: a queue-fed stream driver,
// a model of the stack and its Q31.32 arithmetic, and a checking monitor.
// ----------------------------------------------------------------------------
module tb;
	import rsa_pkg::*;

	typedef struct {
		logic [3:0]  cmd;
		logic [63:0] value;
	} calc_req_t;

	typedef struct {
		logic [63:0] shown;
		bit          vld;
		bit          unf;
		bit          ovf;
		bit          dz;
		logic [7:0]  depth;
	} calc_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // [3:0] cmd, [67:4] push_value, [71:68] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // [63:0] result_value, [64] value_valid,
	                        // [65] underflow_flag, [66] overflow_flag,
	                        // [67] divide_by_zero, [75:68] stack_depth

	calc_req_t   req_q[$];
	calc_res_t   result_q[$];
	logic [63:0] stk[STACK_DEPTH];
	int unsigned sp;
	bit          f_unf, f_ovf;
	int          errs;
	int          send_idle_pct, stall_pct;
	bit          hold_go, hold_seen;
	int          hold_cnt;
	longint      cyc;

	rpn_stack_alu_unit dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	function automatic logic [63:0] pop_word();
		if (sp > 0) begin
			sp--;
			return stk[sp];
		end
		f_unf = 1;
		return 64'd0;
	endfunction

	function automatic void push_word(logic [63:0] w);
		if (sp < STACK_DEPTH) begin
			stk[sp] = w;
			sp++;
		end else
			f_ovf = 1;
	endfunction

	function automatic logic [63:0] mag(logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	function automatic logic [63:0] signed_clamp(logic [127:0] m, bit neg);
		if (neg)
			return (m > {64'd0, SMIN}) ? SMIN : -m[63:0];
		return (m > {64'd0, SMAX}) ? SMAX : m[63:0];
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? SMIN : SMAX;
		return s;
	endfunction

	function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		if (a[63] != b[63] && d[63] != a[63])
			return a[63] ? SMIN : SMAX;
		return d;
	endfunction

	function automatic calc_res_t calc_step(logic [3:0] cmd, logic [63:0] v);
		calc_res_t   r;
		logic [63:0] x, y;
		logic [127:0] w;
		r = '{default: 0};
		f_unf = 0;
		f_ovf = 0;
		case (cmd)
			CMD_PUSH: push_word(v);
			CMD_ADD, CMD_SUB, CMD_MUL: begin
				y = pop_word();
				x = pop_word();
				if (cmd == CMD_ADD)
					push_word(add_sat(x, y));
				else if (cmd == CMD_SUB)
					push_word(sub_sat(x, y));
				else begin
					w = ({64'd0, mag(x)} * {64'd0, mag(y)}) >> 32;
					push_word(signed_clamp(w, x[63] ^ y[63]));
				end
			end
			CMD_DIV, CMD_MOD: begin
				y = pop_word();
				if (y == 0)
					r.dz = 1;
				else begin
					x = pop_word();
					if (cmd == CMD_DIV) begin
						w = ({64'd0, mag(x)} << 32) / {64'd0, mag(y)};
						push_word(signed_clamp(w, x[63] ^ y[63]));
					end else begin
						w = {64'd0, mag(x) % mag(y)};
						push_word(x[63] ? -w[63:0] : w[63:0]);
					end
				end
			end
			CMD_PEEK: if (sp > 0) begin
				r.shown = stk[sp-1];
				r.vld = 1;
			end
			CMD_DUP: begin
				x = pop_word();
				push_word(x);
				push_word(x);
			end
			CMD_SWAP: begin
				x = pop_word();
				y = pop_word();
				push_word(x);
				push_word(y);
			end
			CMD_CLEAR: sp = 0;
			CMD_POP: begin
				r.shown = pop_word();
				r.vld = 1;
			end
			default: ;
		endcase
		r.unf = f_unf;
		r.ovf = f_ovf;
		r.depth = sp[7:0];
		return r;
	endfunction

	// ------------------------------------------------------------ stimulus
	function automatic void add_req(logic [3:0] c, logic [63:0] v);
		req_q.push_back('{cmd: c, value: v});
	endfunction

	function automatic logic [63:0] rand_value();
		logic [63:0] t;
		case ($urandom_range(0, 9))
			0: t = SMAX;
			1: t = SMIN;
			2: t = 64'd0;
			3: begin
				t = 64'($urandom_range(0, 2000));
				t = (t - 64'd1000) << 32;
			end
			4: begin
				t = 64'($urandom_range(0, 2000));
				t = ((t - 64'd1000) << 32) | 64'($urandom);
			end
			5: t = {{32{1'b1}}, 32'($urandom)};
			default: t = {32'($urandom), 32'($urandom)};
		endcase
		return t;
	endfunction

	// Random streams are mostly short expressions, with occasional bursts that
	// fill the stack to its limit so overflow paths get exercised.
	function automatic void gen_random(int n);
		int k, j, np;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 39) == 0) begin
				np = int'($urandom_range(126, 132));
				for (j = 0; j < np; j++)
					add_req(CMD_PUSH, rand_value());
				add_req(CMD_DUP, 64'($urandom));
				add_req(CMD_PEEK, 64'($urandom));
				add_req($urandom_range(0, 1) ? CMD_CLEAR : CMD_SWAP, 64'($urandom));
				k += np + 3;
			end else if ($urandom_range(0, 9) < 4) begin
				add_req(CMD_PUSH, rand_value());
				k++;
			end else begin
				add_req(4'($urandom_range(1, 15)), {32'($urandom), 32'($urandom)});
				k++;
			end
		end
	endfunction

	// Checked at the falling edge so that the driver and monitor have settled.
	task automatic wait_drained();
		while (req_q.size() != 0 || s_tvalid || result_q.size() != 0)
			@(negedge clk);
	endtask

	// --------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				result_q.push_back(calc_step(s_tdata[3:0], s_tdata[67:4]));
			if (!s_tvalid || s_tready) begin
				if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tdata <= {4'd0, req_q[0].value, req_q[0].cmd};
					s_tvalid <= 1'b1;
					void'(req_q.pop_front());
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------- receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt <= 0;
			hold_seen <= 1'b0;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_cnt <= 3000;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// -------------------------------------------------------------- monitor
	always @(posedge clk) begin
		calc_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				$display("%0t: result without request: got %h", $time, m_tdata);
				errs++;
			end else begin
				e = result_q.pop_front();
				if (m_tdata[63:0] !== e.shown) begin
					$display("%0t: result_value exp %h got %h", $time, e.shown, m_tdata[63:0]);
					errs++;
				end
				if (m_tdata[64] !== e.vld) begin
					$display("%0t: value_valid exp %0d got %0d", $time, e.vld, m_tdata[64]);
					errs++;
				end
				if (m_tdata[65] !== e.unf) begin
					$display("%0t: underflow_flag exp %0d got %0d", $time, e.unf, m_tdata[65]);
					errs++;
				end
				if (m_tdata[66] !== e.ovf) begin
					$display("%0t: overflow_flag exp %0d got %0d", $time, e.ovf, m_tdata[66]);
					errs++;
				end
				if (m_tdata[67] !== e.dz) begin
					$display("%0t: divide_by_zero exp %0d got %0d", $time, e.dz, m_tdata[67]);
					errs++;
				end
				if (m_tdata[75:68] !== e.depth) begin
					$display("%0t: stack_depth exp %0d got %0d", $time, e.depth,
						m_tdata[75:68]);
					errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > 3_000_000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------ sequence
	initial begin
		int ph;
		cyc = 0;
		errs = 0;
		sp = 0;
		hold_go = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		add_req(CMD_PEEK, 64'd0);
		add_req(CMD_POP, 64'd0);
		add_req(CMD_DIV, 64'd0);
		add_req(CMD_PUSH, SMAX);
		add_req(CMD_PUSH, 64'h1_0000_0000);
		add_req(CMD_ADD, 64'd0);
		add_req(CMD_PUSH, SMIN);
		add_req(CMD_SUB, 64'd0);
		add_req(CMD_PUSH, 64'h3_0000_0000);
		add_req(CMD_MUL, 64'd0);
		add_req(CMD_PUSH, 64'd0);
		add_req(CMD_DIV, 64'd0);
		add_req(CMD_PUSH, 64'hFFFF_FFFE_0000_0000);
		add_req(CMD_MOD, 64'd0);
		add_req(CMD_PUSH, 64'h2_8000_0000);
		add_req(CMD_DIV, 64'd0);
		add_req(CMD_DUP, 64'd0);
		add_req(CMD_SWAP, 64'd0);
		add_req(CMD_PEEK, 64'd0);
		add_req(CMD_POP, 64'd0);
		add_req(CMD_CLEAR, 64'd0);
		add_req(CMD_DUP, 64'd0);
		add_req(CMD_SWAP, 64'd0);
		add_req(4'd15, {64{1'b1}});
		add_req(4'd11, 64'h5555_5555_5555_5555);
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 70 : 0;
			stall_pct = (ph == 2 || ph == 3) ? 70 : 0;
			if (ph == 3) begin
				send_idle_pct = 11;
				stall_pct = 11;
			end
			if (ph == 0)
				hold_go = ~hold_go;
			gen_random(400);
			wait_drained();
		end
		repeat (200) @(posedge clk);

		if (errs == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
